FILE: rtl/lkvc_pkg.sv
// Package for the LRU key/value cache.
// Holds the action codes used by the back end, plus the capacity width and reset. No dependencies.
package lkvc_pkg;
    localparam logic ACT_GET    = 1'b0;
    localparam logic ACT_INSERT = 1'b1;
    localparam int   CAP_BITS   = 4;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;
endpackage

FILE: rtl/lkvc_req_if.sv
// Request channel interface: valid/ready plus action, key and value.
// Used by the top level and the front end.
interface lkvc_req_if #(parameter int KEY_BITS = 32, parameter int VALUE_BITS = 32);
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    modport source (output valid, action, key, value, input ready);
    modport sink   (input valid, action, key, value, output ready);
endinterface

FILE: rtl/lkvc_rsp_if.sv
// Response channel interface: valid/ready plus hit and read value.
// Used by the top level and the back end.
interface lkvc_rsp_if #(parameter int VALUE_BITS = 32);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

FILE: rtl/lkvc_front.sv
// Front end: accepts request words into a two-deep queue.
// Depends on lkvc_pkg and lkvc_req_if.
module lkvc_front import lkvc_pkg::*; #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lkvc_req_if.sink              i_req,
    output logic                  o_q_valid,
    input  logic                  i_q_pop,
    output logic                  o_q_action,
    output logic [KEY_BITS-1:0]   o_q_key,
    output logic [VALUE_BITS-1:0] o_q_value
);
    localparam int W = 1 + KEY_BITS + VALUE_BITS;
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign i_req.ready = (r_cnt != 2'd2);
    assign push = i_req.valid && i_req.ready;
    assign pop  = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign {o_q_action, o_q_key, o_q_value} = r_mem[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= {i_req.action, i_req.key, i_req.value};
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: rtl/lkvc_back.sv
// Back end: two-step sequencer doing lookup, then update and response.
// Depends on lkvc_pkg and lkvc_rsp_if.
module lkvc_back import lkvc_pkg::*; #(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CAP_BITS-1:0]   i_capacity,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  logic                  i_q_action,
    input  logic [KEY_BITS-1:0]   i_q_key,
    input  logic [VALUE_BITS-1:0] i_q_value,
    lkvc_rsp_if.source            o_rsp
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = $clog2(ENTRIES + 1);

    typedef enum logic {S_LOOK, S_UPD} t_state;

    logic [KEY_BITS-1:0]   r_keys [ENTRIES];
    logic [VALUE_BITS-1:0] r_vals [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [RW-1:0]         r_rank [ENTRIES];
    t_state                r_state;
    logic                  r_hit, r_free_ok, r_rsp_valid, r_rsp_hit;
    logic [IW-1:0]         r_slot, r_free, r_old;
    logic [RW-1:0]         r_cnt;
    logic [VALUE_BITS-1:0] r_rsp_val;

    logic              hit, free_ok;
    logic [IW-1:0]     slot, free_s, old_s;
    logic [RW-1:0]     cnt, cap;

    // lookup: match, first free slot, oldest slot, count
    always_comb begin
        hit = 1'b0; slot = '0; free_ok = 1'b0; free_s = '0; old_s = '0; cnt = '0;
        for (int s = ENTRIES - 1; s >= 0; s--) begin
            if (r_valid[s] && r_keys[s] == i_q_key) begin hit = 1'b1; slot = IW'(s); end
            if (!r_valid[s]) begin free_ok = 1'b1; free_s = IW'(s); end
        end
        for (int s = 0; s < ENTRIES; s++) begin
            if (r_valid[s]) begin
                cnt = cnt + 1'b1;
                if (r_rank[s] == cnt - 1'b1 && r_rank[s] >= r_rank[old_s]) old_s = IW'(s);
            end
        end
        // oldest is the valid slot of highest rank; ranks are 0..count-1 and unique
        for (int s = 0; s < ENTRIES; s++)
            if (r_valid[s] && r_rank[s] == cnt - 1'b1) old_s = IW'(s);
    end

    // effective capacity clamped to 1..ENTRIES
    always_comb begin
        if (i_capacity == '0) cap = RW'(1);
        else if (32'(i_capacity) > ENTRIES) cap = RW'(ENTRIES);
        else cap = RW'(i_capacity);
    end

    assign o_q_pop = (r_state == S_UPD);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.hit = r_rsp_hit;
    assign o_rsp.read_value = r_rsp_val;

    // sequencer, entry store and response register
    always_ff @(posedge i_clk) begin
        logic [IW-1:0]  tgt;
        logic [RW-1:0]  pr, ncnt;
        logic           fresh;
        tgt = '0; pr = '0; ncnt = '0; fresh = 1'b0;
        if (!i_rst_n) begin
            r_state <= S_LOOK; r_valid <= '0; r_rsp_valid <= 1'b0;
            for (int s = 0; s < ENTRIES; s++) r_rank[s] <= '0;
        end else begin
            // response register is always empty by the update step
            if (o_rsp.ready && r_state == S_LOOK) r_rsp_valid <= 1'b0;
            case (r_state)
                S_LOOK: begin
                    if (i_q_valid && (!r_rsp_valid || o_rsp.ready)) begin
                        r_hit <= hit; r_slot <= slot; r_free_ok <= free_ok;
                        r_free <= free_s; r_old <= old_s; r_cnt <= cnt;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_state <= S_LOOK;
                    r_rsp_valid <= 1'b1;
                    r_rsp_hit <= r_hit;
                    r_rsp_val <= (r_hit && i_q_action == ACT_GET) ? r_vals[r_slot] : '0;
                    if (r_hit) begin
                        // promote: younger slots age by one
                        pr = r_rank[r_slot];
                        for (int s = 0; s < ENTRIES; s++)
                            if (r_valid[s] && r_rank[s] < pr) r_rank[s] <= r_rank[s] + 1'b1;
                        r_rank[r_slot] <= '0;
                        if (i_q_action == ACT_INSERT) r_vals[r_slot] <= i_q_value;
                        ncnt = r_cnt;
                    end else if (i_q_action == ACT_INSERT) begin
                        fresh = 1'b1;
                        tgt = r_free_ok ? r_free : r_old;
                        ncnt = r_free_ok ? r_cnt + 1'b1 : r_cnt;
                        r_keys[tgt] <= i_q_key;
                        r_vals[tgt] <= i_q_value;
                        for (int s = 0; s < ENTRIES; s++)
                            if (r_valid[s] && IW'(s) != tgt) r_rank[s] <= r_rank[s] + 1'b1;
                        r_rank[tgt] <= '0;
                    end
                    if (i_q_action == ACT_INSERT) begin
                        // drop least recent if over capacity (never the new entry);
                        // after a promote of the oldest slot the next one in line goes
                        for (int s = 0; s < ENTRIES; s++) begin
                            if (r_valid[s] && IW'(s) == tgt && fresh)
                                r_valid[s] <= 1'b1;
                            else if (fresh && IW'(s) == tgt)
                                r_valid[s] <= 1'b1;
                            else if (r_valid[s] && ncnt > cap) begin
                                if ((fresh && r_rank[s] == ncnt - RW'(2)) ||
                                    (!fresh && IW'(s) != r_slot &&
                                     r_rank[s] == ((pr == ncnt - RW'(1)) ?
                                                   ncnt - RW'(2) : ncnt - RW'(1))))
                                    r_valid[s] <= 1'b0;
                            end
                        end
                    end
                end
                default: r_state <= S_LOOK;
            endcase
        end
    end
endmodule

FILE: rtl/lru_key_value_cache.sv
// Top level of the LRU key/value cache.
// Depends on lkvc_pkg, lkvc_req_if, lkvc_rsp_if, lkvc_front, lkvc_back.
//
// Usage:
//   i_req carries request words (action, key, value) under valid/ready; o_rsp
//   returns one response word (hit, read_value) per request, in order.
//   i_cfg_we/i_cfg_wdata write the capacity register (write only while idle).
// Path: an accepted request is written into the front queue; the back end
//   registers its lookup in the lookup step, then registers the response in
//   the update step.
// Requests: the back end takes a new request only after the update step of
//   the last one, as both steps work on the shared entry store.
// Reset: all entries become invalid and capacity returns to 8.
// Stall: a stalled response holds in its register; the back end stops before
//   the next lookup, the two-word front queue fills and then drops ready.
module lru_key_value_cache import lkvc_pkg::*; #(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CAP_BITS-1:0] i_cfg_wdata,
    lkvc_req_if.sink            i_req,
    lkvc_rsp_if.source          o_rsp
);
    logic [CAP_BITS-1:0]   r_capacity;
    logic                  q_valid, q_pop, q_action;
    logic [KEY_BITS-1:0]   q_key;
    logic [VALUE_BITS-1:0] q_value;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_capacity <= CAP_RESET;
        else if (i_cfg_we) r_capacity <= i_cfg_wdata;
    end

    lkvc_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_req,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_action(q_action),
        .o_q_key(q_key), .o_q_value(q_value)
    );

    lkvc_back #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_capacity(r_capacity),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_action(q_action),
        .i_q_key(q_key), .i_q_value(q_value), .o_rsp
    );
endmodule
